// File: src/xmbr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Shared result codes, response bytes, the result record and the CRC-16 step.
// ----------------------------------------------------------------------------
package xmbr_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;
    localparam logic [1:0] KIND_EOT  = 2'd3;

    // Link control bytes
    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;

    // CRC-16, poly 0x1021, MSB first
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam int unsigned OFFSET_W = 7;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          value;
        logic [OFFSET_W-1:0] offset;
    } result_t;

    // One byte through the CRC: eight shift/xor steps
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/xmodem_block_receiver.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver
// Deframes XMODEM blocks from a byte stream, forwards data bytes with their
// offset and answers ACK, NAK or end of transfer per block.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake           Payload
//  -------   ---  ------------------  ---------------------
//  input     in   in_valid/in_stall   rx_byte
//  output    out  out_valid/out_stall kind, value, offset
//  config    in   cfg_we              cfg_wdata (first block number)
//
//  Cycles: one byte per cycle while in_stall is low; each byte is decoded in the
//  cycle it is accepted and its result (if any) is registered in the output
//  register, or in the skid register while the output is stalled.
//  Reset: asynchronous, active low; parser goes to waiting for a block start
//  and the expected block number returns to 1.
//  Stalls: a skid register catches one result while the output is stalled;
//  in_stall rises only once the skid register is full.
//
module xmodem_block_receiver #(
    parameter int unsigned BLOCK_BYTES = 128
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic [6:0] offset
);

    localparam int unsigned CNT_W = $clog2(BLOCK_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BYTES - 1);

    // Parser phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_NUM  = 3'd1;
    localparam logic [2:0] PH_CMP  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CHK1 = 3'd4;
    localparam logic [2:0] PH_CHK2 = 3'd5;

    // Parser state
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       first_block_reg;
    logic [7:0]       expected_reg, expected_next;
    logic [7:0]       got_block_reg, got_block_next;
    logic             header_ok_reg, header_ok_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       first_check_reg, first_check_next;

    // Result path: main output register plus one skid entry
    logic                 out_valid_reg;
    xmbr_pkg::result_t    out_reg;
    logic                 skid_valid_reg;
    xmbr_pkg::result_t    skid_reg;

    logic                 accept;
    logic                 out_take;
    logic                 res_valid;
    xmbr_pkg::result_t    res;
    logic                 block_ok;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign value     = out_reg.value;
    assign offset    = out_reg.offset;

    // The header must be good, and the CRC must match both check bytes or the sum must match the first one
    assign block_ok = header_ok_reg &&
                      ((crc_reg == {first_check_reg, rx_byte}) ||
                       (first_check_reg == sum_reg));

    // Byte decode
    always_comb
    begin
        phase_next       = phase_reg;
        expected_next    = expected_reg;
        got_block_next   = got_block_reg;
        header_ok_next   = header_ok_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        sum_next         = sum_reg;
        first_check_next = first_check_reg;
        res_valid        = 1'b0;
        res.kind         = xmbr_pkg::KIND_DATA;
        res.value        = rx_byte;
        res.offset       = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == xmbr_pkg::CODE_SOH) begin
                    phase_next       = PH_NUM;
                    header_ok_next   = 1'b0;
                    count_next       = '0;
                    crc_next         = '0;
                    sum_next         = '0;
                    first_check_next = '0;
                end
                else if (rx_byte == xmbr_pkg::CODE_EOT) begin
                    // end of transfer; ready for a new one
                    expected_next = first_block_reg;
                    res_valid     = 1'b1;
                    res.kind      = xmbr_pkg::KIND_EOT;
                    res.value     = xmbr_pkg::CODE_ACK;
                end
            end
            PH_NUM:
            begin
                got_block_next = rx_byte;
                phase_next     = PH_CMP;
            end
            PH_CMP:
            begin
                header_ok_next = (got_block_reg == expected_reg) &&
                                 (rx_byte == ~got_block_reg);
                phase_next     = PH_DATA;
            end
            PH_DATA:
            begin
                crc_next   = xmbr_pkg::crc_update(crc_reg, rx_byte);
                sum_next   = sum_reg + rx_byte;
                res_valid  = 1'b1;
                res.offset = count_reg[xmbr_pkg::OFFSET_W-1:0];
                if (count_reg == CNT_LAST) begin
                    count_next = '0;
                    phase_next = PH_CHK1;
                end
                else begin
                    count_next = count_reg + 1'b1;
                end
            end
            PH_CHK1:
            begin
                first_check_next = rx_byte;
                phase_next       = PH_CHK2;
            end
            PH_CHK2:
            begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                if (block_ok) begin
                    expected_next = expected_reg + 8'd1;
                    res.kind      = xmbr_pkg::KIND_ACK;
                    res.value     = xmbr_pkg::CODE_ACK;
                end
                else begin
                    res.kind  = xmbr_pkg::KIND_NAK;
                    res.value = xmbr_pkg::CODE_NAK;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Parser registers; a config write also reloads the expected number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            first_block_reg <= 8'd1;
            expected_reg    <= 8'd1;
            got_block_reg   <= '0;
            header_ok_reg   <= 1'b0;
            count_reg       <= '0;
            crc_reg         <= '0;
            sum_reg         <= '0;
            first_check_reg <= '0;
        end
        else begin
            if (accept) begin
                phase_reg       <= phase_next;
                expected_reg    <= expected_next;
                got_block_reg   <= got_block_next;
                header_ok_reg   <= header_ok_next;
                count_reg       <= count_next;
                crc_reg         <= crc_next;
                sum_reg         <= sum_next;
                first_check_reg <= first_check_next;
            end
            if (cfg_we) begin
                first_block_reg <= cfg_wdata;
                expected_reg    <= cfg_wdata;
            end
        end
    end

    // Output and skid valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            if (skid_valid_reg) begin
                if (out_take) begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept && res_valid) begin
                if (out_valid_reg && !out_take) begin
                    skid_valid_reg <= 1'b1;
                end
                else begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res_valid) begin
            if (out_valid_reg && !out_take) begin
                skid_reg <= res;
            end
            else begin
                out_reg <= res;
            end
        end
    end

endmodule

// File: src/xmbr_checker.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver port checker
// Watches the top-level ports for result encoding and output transfer rules.
// ----------------------------------------------------------------------------
module xmbr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] value,
    input logic [6:0] offset
);

    // No result shown in the cycle after a reset edge
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // Stalled result holds until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
                                  && $stable(offset))
        else $error("stalled result changed");

    // Responses carry the right byte
    a_resp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != xmbr_pkg::KIND_DATA |->
            (kind == xmbr_pkg::KIND_NAK && value == xmbr_pkg::CODE_NAK) ||
            (kind != xmbr_pkg::KIND_NAK && value == xmbr_pkg::CODE_ACK))
        else $error("response byte does not match kind");

    // Responses carry zero offset
    a_resp_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != xmbr_pkg::KIND_DATA |-> offset == 7'd0)
        else $error("nonzero offset on a response");

endmodule

bind xmodem_block_receiver xmbr_checker u_xmbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .offset    (offset)
);
